>>> rtl/pcm_voice_mixer_point_resample_top_assert.svh
// Assertion macros for the voice mixer top level.
// Depends on clk and rst being visible where the macros are used.
`ifndef PCM_VOICE_MIXER_POINT_RESAMPLE_TOP_ASSERT_SVH
`define PCM_VOICE_MIXER_POINT_RESAMPLE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pvm assertion failed");
`define PVM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvm implication failed");
`else
`define PVM_ASSERT(lbl, prop)
`define PVM_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> rtl/pvm_pkg.sv
// Package for the voice mixer: field widths, codes, register indexes, state type.
// No dependencies.
`default_nettype none
package pvm_pkg;

  localparam int ADDR_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int LENGTH_W    = 17;
  localparam int RATE_W      = 18;
  localparam int STEP_W      = 32;
  localparam int VOICE_ID_W  = 3;
  localparam int ACTIVE_W    = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CHANNELS_W  = 2;

  localparam logic [RATE_W-1:0]     DEVICE_RATE_RESET   = 18'd48000;
  localparam logic [RATE_W-1:0]     RATE_MIN            = 18'h1;
  localparam logic [CHANNELS_W-1:0] CHANNEL_COUNT_RESET = 2'd2;
  localparam logic [ACTIVE_W-1:0]   ACTIVE_MAX          = 4'd15;

  localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_RATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_TICK,
    ST_DRAIN,
    ST_SUM,
    ST_OUT0,
    ST_OUT1
  } state_t;

endpackage
`default_nettype wire

>>> rtl/pvm_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module pvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/pvm_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to STEP_W bits.
// Depends on pvm_pkg.
`default_nettype none
module pvm_div #(
  parameter int DW = 38
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [DW-1:0]                 dividend,
  input  wire logic [pvm_pkg::RATE_W-1:0]    divisor,
  output logic                               done,
  output logic [pvm_pkg::STEP_W-1:0]         quotient
);
  localparam int NW   = pvm_pkg::RATE_W;
  localparam int QW   = pvm_pkg::STEP_W;
  localparam int XW   = (DW > QW) ? DW : QW + 1;
  localparam int CNTW = $clog2(DW + 1);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   dvd;
  logic [NW-1:0]   dvs;
  logic [NW-1:0]   rem;
  logic [XW-1:0]   quo;
  logic [NW:0]     trial;
  logic            ge;

  assign trial = {rem, dvd[DW-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(DW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (run) begin
      dvd <= dvd << 1;
      rem <= ge ? NW'(trial - {1'b0, dvs}) : NW'(trial);
      quo <= {quo[XW-2:0], ge};
    end
  end

  assign quotient = (|quo[XW-1:QW]) ? '1 : quo[QW-1:0];

endmodule
`default_nettype wire

>>> rtl/pcm_voice_mixer_point_resample_top.sv
// Voice mixer top level: request control, voice table and sample store, tick pipeline.
// Depends on pvm_pkg, pvm_ram, pvm_div and the assertion macro header.
//
// A request is taken when start is high and busy is low. Results come out on the
// result ports for one cycle each, marked by strobe, and cannot be held off.
// A sample write or an unknown op gives its result in the cycle after the request.
// A voice start scans the active flags one voice a cycle; with no free voice the
// result has status set, else the phase step divider runs for the first free voice
// and the result follows in the cycle after it is done. A tick reads the voice table
// one voice a cycle and the sample store one word a cycle in a three-stage pipeline;
// the first result follows DRAIN and SUM and the second channel, if any, the cycle
// after. SAMPLE_WORDS must be a power of two. No clearing pass runs after reset.
`default_nettype none
`include "pcm_voice_mixer_point_resample_top_assert.svh"
module pcm_voice_mixer_point_resample_top #(
  parameter int NUM_VOICES   = 8,
  parameter int SAMPLE_WORDS = 65536,
  parameter int FRAC_BITS    = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [1:0]                             op,
  input  wire logic [pvm_pkg::ADDR_W-1:0]             address,
  input  wire logic signed [pvm_pkg::SAMPLE_W-1:0]    sample_value,
  input  wire logic [pvm_pkg::LENGTH_W-1:0]           length,
  input  wire logic [pvm_pkg::RATE_W-1:0]             source_rate,
  input  wire logic                                   loop_enable,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [pvm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [pvm_pkg::RATE_W-1:0]             cfg_data,
  output logic                                        strobe,
  output logic signed [pvm_pkg::SAMPLE_W-1:0]         mix_sample,
  output logic                                        channel,
  output logic                                        last,
  output logic                                        status,
  output logic [pvm_pkg::VOICE_ID_W-1:0]              voice_id,
  output logic [pvm_pkg::ACTIVE_W-1:0]                active_voices
);
  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW    = $clog2(NUM_VOICES + 1);
  localparam int AW    = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam int LW    = pvm_pkg::LENGTH_W;
  localparam int PW    = LW + FRAC_BITS;
  localparam int SUMW  = ((PW > pvm_pkg::STEP_W) ? PW : pvm_pkg::STEP_W) + 1;
  localparam int IW    = SUMW - FRAC_BITS;
  localparam int VRW   = pvm_pkg::ADDR_W + LW + PW + pvm_pkg::STEP_W + 1;
  localparam int DW    = pvm_pkg::RATE_W + FRAC_BITS;
  localparam int ACCW  = pvm_pkg::SAMPLE_W + VW + 1;
  localparam logic [VW-1:0] LAST_VOICE = VW'(NUM_VOICES - 1);
  localparam logic signed [ACCW-1:0] ACC_HI = ACCW'(pvm_pkg::Q15_MAX);
  localparam logic signed [ACCW-1:0] ACC_LO = ACCW'(pvm_pkg::Q15_MIN);

  pvm_pkg::state_t state, state_next;

  logic [pvm_pkg::RATE_W-1:0]     device_rate;
  logic [pvm_pkg::CHANNELS_W-1:0] channel_count;

  logic [pvm_pkg::ADDR_W-1:0]     req_address;
  logic [LW-1:0]                  req_length;
  logic [pvm_pkg::RATE_W-1:0]     req_source_rate;
  logic                           req_loop;

  logic [NUM_VOICES-1:0] active;
  logic [CW-1:0]         count;
  logic [VW-1:0]         scan_idx;
  logic [VW-1:0]         rd_idx;
  logic                  b_valid;
  logic [VW-1:0]         b_idx;
  logic                  c_add;
  logic signed [ACCW-1:0] acc;

  logic accept, nch2, found, scan_last, rd_last, claim, div_start, div_done;
  logic [pvm_pkg::STEP_W-1:0] div_quotient;
  logic [pvm_pkg::RATE_W-1:0] divisor;

  logic             samp_we;
  logic [AW-1:0]    samp_raddr;
  logic [pvm_pkg::SAMPLE_W-1:0] samp_rdata;

  logic             vram_we;
  logic [VW-1:0]    vram_waddr;
  logic [VRW-1:0]   vram_wdata;
  logic [VRW-1:0]   vram_rdata;

  logic [pvm_pkg::ADDR_W-1:0] b_base;
  logic [LW-1:0]              b_length;
  logic [PW-1:0]              b_phase;
  logic [pvm_pkg::STEP_W-1:0] b_step;
  logic                       b_loops;
  logic                       b_act;
  logic [LW-1:0]              b_int;
  logic [SUMW-1:0]            b_sum;
  logic                       b_wrap;
  logic                       b_read;
  logic                       b_free;
  logic [PW-1:0]              b_phase_new;

  logic                              emit;
  logic signed [pvm_pkg::SAMPLE_W-1:0] e_mix;
  logic                              e_ch;
  logic                              e_last;
  logic                              e_status;
  logic [pvm_pkg::VOICE_ID_W-1:0]    e_vid;
  logic [CW-1:0]                     cnt_after;
  logic signed [pvm_pkg::SAMPLE_W-1:0] mix_sat;

  assign busy      = state != pvm_pkg::ST_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign nch2      = channel_count[1];
  assign found     = !active[scan_idx];
  assign scan_last = scan_idx == LAST_VOICE;
  assign rd_last   = rd_idx == LAST_VOICE;
  assign divisor   = (device_rate == '0) ? pvm_pkg::RATE_MIN : device_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_rate   <= pvm_pkg::DEVICE_RATE_RESET;
      channel_count <= pvm_pkg::CHANNEL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pvm_pkg::REG_DEVICE_RATE:   device_rate   <= cfg_data;
        pvm_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[pvm_pkg::CHANNELS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_address     <= address;
      req_length      <= length;
      req_source_rate <= source_rate;
      req_loop        <= loop_enable;
    end
  end

  // stage B: voice entry read last cycle
  assign {b_base, b_length, b_phase, b_step, b_loops} = vram_rdata;
  assign b_act       = b_valid && active[b_idx];
  assign b_int       = b_phase[PW-1:FRAC_BITS];
  assign b_sum       = SUMW'(b_phase) + SUMW'(b_step);
  assign b_wrap      = b_sum[SUMW-1:FRAC_BITS] >= IW'(b_length);
  assign b_read      = b_int < b_length;
  assign b_free      = b_wrap && !b_loops;
  assign b_phase_new = b_wrap ? '0 : PW'(b_sum);
  assign samp_raddr  = AW'(18'(b_base) + 18'(b_int));

  always_comb begin
    if (claim) begin
      vram_we    = 1'b1;
      vram_waddr = scan_idx;
      vram_wdata = {req_address, req_length, {PW{1'b0}}, div_quotient, req_loop};
    end else begin
      vram_we    = b_act;
      vram_waddr = b_idx;
      vram_wdata = {b_base, b_length, b_phase_new, b_step, b_loops};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pvm_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pvm_pkg::OP_START: state_next = pvm_pkg::ST_SCAN;
            pvm_pkg::OP_TICK:  state_next = pvm_pkg::ST_TICK;
            default:           state_next = pvm_pkg::ST_IDLE;
          endcase
        end
      end
      pvm_pkg::ST_SCAN: begin
        if (found) state_next = pvm_pkg::ST_DIV;
        else if (scan_last) state_next = pvm_pkg::ST_IDLE;
      end
      pvm_pkg::ST_DIV:   if (div_done) state_next = pvm_pkg::ST_IDLE;
      pvm_pkg::ST_TICK:  if (rd_last) state_next = pvm_pkg::ST_DRAIN;
      pvm_pkg::ST_DRAIN: state_next = pvm_pkg::ST_SUM;
      pvm_pkg::ST_SUM:   state_next = pvm_pkg::ST_OUT0;
      pvm_pkg::ST_OUT0:  state_next = nch2 ? pvm_pkg::ST_OUT1 : pvm_pkg::ST_IDLE;
      pvm_pkg::ST_OUT1:  state_next = pvm_pkg::ST_IDLE;
      default:           state_next = pvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    samp_we   = 1'b0;
    div_start = 1'b0;
    claim     = 1'b0;
    emit      = 1'b0;
    e_mix     = '0;
    e_ch      = 1'b0;
    e_last    = 1'b0;
    e_status  = 1'b0;
    e_vid     = '0;
    case (state)
      pvm_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pvm_pkg::OP_WRITE: begin
              samp_we = 1'b1;
              emit    = 1'b1;
              e_last  = 1'b1;
            end
            pvm_pkg::OP_START, pvm_pkg::OP_TICK: ;
            default: begin
              emit   = 1'b1;
              e_last = 1'b1;
            end
          endcase
        end
      end
      pvm_pkg::ST_SCAN: begin
        if (found) begin
          div_start = 1'b1;
        end else if (scan_last) begin
          emit     = 1'b1;
          e_last   = 1'b1;
          e_status = 1'b1;
        end
      end
      pvm_pkg::ST_DIV: begin
        if (div_done) begin
          claim  = 1'b1;
          emit   = 1'b1;
          e_last = 1'b1;
          e_vid  = pvm_pkg::VOICE_ID_W'(scan_idx);
        end
      end
      pvm_pkg::ST_OUT0: begin
        emit   = 1'b1;
        e_mix  = mix_sat;
        e_last = !nch2;
      end
      pvm_pkg::ST_OUT1: begin
        emit   = 1'b1;
        e_mix  = mix_sat;
        e_ch   = 1'b1;
        e_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (acc > ACC_HI) mix_sat = pvm_pkg::Q15_MAX;
    else if (acc < ACC_LO) mix_sat = pvm_pkg::Q15_MIN;
    else mix_sat = acc[pvm_pkg::SAMPLE_W-1:0];
  end

  assign cnt_after = claim ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pvm_pkg::ST_IDLE;
      active  <= '0;
      count   <= '0;
      b_valid <= 1'b0;
      c_add   <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      b_valid <= state == pvm_pkg::ST_TICK;
      c_add   <= b_act && b_read;
      strobe  <= emit;
      if (claim) begin
        active[scan_idx] <= 1'b1;
        count            <= count + 1'b1;
      end else if (b_act && b_free) begin
        active[b_idx] <= 1'b0;
        count         <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_idx <= rd_idx;
    if (accept) begin
      scan_idx <= '0;
      rd_idx   <= '0;
    end else begin
      if (state == pvm_pkg::ST_SCAN && !found && !scan_last) scan_idx <= scan_idx + 1'b1;
      if (state == pvm_pkg::ST_TICK && !rd_last) rd_idx <= rd_idx + 1'b1;
    end
    if (accept) begin
      acc <= '0;
    end else if (c_add) begin
      acc <= acc + ACCW'(signed'(samp_rdata));
    end
    if (emit) begin
      mix_sample    <= e_mix;
      channel       <= e_ch;
      last          <= e_last;
      status        <= e_status;
      voice_id      <= e_vid;
      active_voices <= (cnt_after > CW'(pvm_pkg::ACTIVE_MAX)) ? pvm_pkg::ACTIVE_MAX
                                                            : pvm_pkg::ACTIVE_W'(cnt_after);
    end
  end

  pvm_ram #(
    .WIDTH(pvm_pkg::SAMPLE_W),
    .DEPTH(SAMPLE_WORDS)
  ) u_samples (
    .clk  (clk),
    .we   (samp_we),
    .waddr(AW'(address)),
    .wdata(sample_value),
    .raddr(samp_raddr),
    .rdata(samp_rdata)
  );

  pvm_ram #(
    .WIDTH(VRW),
    .DEPTH(NUM_VOICES)
  ) u_voices (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_waddr),
    .wdata(vram_wdata),
    .raddr(rd_idx),
    .rdata(vram_rdata)
  );

  pvm_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({req_source_rate, {FRAC_BITS{1'b0}}}),
    .divisor (divisor),
    .done    (div_done),
    .quotient(div_quotient)
  );

  `PVM_ASSERT(a_count_matches, count == $countones(active))
  `PVM_ASSERT_IMPL(a_idle_drained, !busy, !b_valid && !c_add)
  `PVM_ASSERT_IMPL(a_claim_free, claim, !active[scan_idx])
  `PVM_ASSERT(a_second_channel, strobe && !last |=> strobe && last && channel)

endmodule
`default_nettype wire
